@@ design/kcmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcmd_pkg
// Shared codes for the key/value command record parser: parse phases,
// opcode bytes, byte roles, verdicts, the result width and field byte counts.
// ----------------------------------------------------------------------------
package kcmd_pkg;

  localparam int unsigned OUT_TDATA_W = 152;

  // parse phases
  localparam logic [2:0] PH_OP     = 3'd0;
  localparam logic [2:0] PH_KLEN   = 3'd1;
  localparam logic [2:0] PH_KEY    = 3'd2;
  localparam logic [2:0] PH_VLEN   = 3'd3;
  localparam logic [2:0] PH_VAL    = 3'd4;
  localparam logic [2:0] PH_EXP    = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;
  localparam logic [2:0] PH_IGNORE = 3'd7;

  // opcode bytes
  localparam logic [7:0] OP_SET    = 8'h53;
  localparam logic [7:0] OP_DEL    = 8'h44;
  localparam logic [7:0] OP_SETEXP = 8'h54;
  localparam logic [7:0] OP_EXPIRE = 8'h45;
  localparam logic [7:0] OP_NOOP   = 8'h4E;

  // byte roles
  localparam logic [2:0] ROLE_OP      = 3'd0;
  localparam logic [2:0] ROLE_KLEN    = 3'd1;
  localparam logic [2:0] ROLE_KEY     = 3'd2;
  localparam logic [2:0] ROLE_VLEN    = 3'd3;
  localparam logic [2:0] ROLE_VAL     = 3'd4;
  localparam logic [2:0] ROLE_EXP     = 3'd5;
  localparam logic [2:0] ROLE_IGNORED = 3'd6;

  // verdicts
  localparam logic [1:0] VERDICT_OK        = 2'd0;
  localparam logic [1:0] VERDICT_BAD_OP    = 2'd1;
  localparam logic [1:0] VERDICT_TRUNCATED = 2'd2;
  localparam logic [1:0] VERDICT_NOOP_XTRA = 2'd3;

  localparam logic [2:0]  FLD_LEN_BYTES = 3'd4;
  localparam logic [3:0]  FLD_EXP_BYTES = 4'd8;

endpackage

@@ design/key_value_command_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_command_parser
// Byte-serial parser for one key/value command record.
// ----------------------------------------------------------------------------
// Input channel in_*: one record byte per request in in_tdata, in_tlast on
// the record's final byte. Output channel out_*: one result per input byte,
// carrying the byte's role in out_tuser, the byte itself, the verdict (valid
// when out_tlast is high), the opcode, both lengths and the expiry.
// The parse state update and the result are formed from the incoming byte and
// the phase registers in a single pass and land in the output register.
// Throughput is one byte per cycle; the input is taken whenever the output
// register is empty or is being drained in the same cycle, so a stalled
// receiver holds the result and back-pressures the input after one request.
// Reset empties the output register and returns the parser to the opcode
// phase with all fields cleared; the same clearing happens after every byte
// marked last.
// ----------------------------------------------------------------------------
module key_value_command_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // data_byte
  input  logic                              in_tlast,   // last_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // byte_out[7:0], verdict[9:8], op_code[17:10], key_length[49:18],
  // value_length[81:50], expiry_ms[145:82], zero fill[151:146]
  output logic [kcmd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [2:0]                        out_tuser,  // byte_role
  output logic                              out_tlast   // record_end
);
  import kcmd_pkg::*;

  logic [2:0]  phase_r,     phase_nxt;
  logic [31:0] remain_r,    remain_nxt;
  logic [7:0]  opcode_r,    opcode_nxt;
  logic [31:0] key_len_r,   key_len_nxt;
  logic [31:0] val_len_r,   val_len_nxt;
  logic [63:0] expiry_r,    expiry_nxt;
  logic [1:0]  error_r,     error_nxt;

  logic        out_valid_r;
  logic [2:0]  role_r,      role_nxt;
  logic [7:0]  byte_r;
  logic        end_r;
  logic [1:0]  verdict_r,   verdict_nxt;
  logic [7:0]  res_op_r;
  logic [31:0] res_klen_r;
  logic [31:0] res_vlen_r;
  logic [63:0] res_exp_r,   res_exp_nxt;

  logic        accept;
  logic [31:0] remain_dec;
  logic [31:0] shift_klen;
  logic [31:0] shift_vlen;
  logic        op_valid;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign remain_dec = remain_r - 32'd1;
  assign shift_klen = {key_len_r[23:0], in_tdata};
  assign shift_vlen = {val_len_r[23:0], in_tdata};
  assign op_valid   = (in_tdata == OP_SET) || (in_tdata == OP_DEL) ||
                      (in_tdata == OP_SETEXP) || (in_tdata == OP_EXPIRE);

  always_comb begin
    phase_nxt   = phase_r;
    remain_nxt  = remain_r;
    opcode_nxt  = opcode_r;
    key_len_nxt = key_len_r;
    val_len_nxt = val_len_r;
    expiry_nxt  = expiry_r;
    error_nxt   = error_r;
    role_nxt    = ROLE_IGNORED;
    case (phase_r)
      PH_OP: begin
        role_nxt   = ROLE_OP;
        opcode_nxt = in_tdata;
        if (in_tdata == OP_NOOP) begin
          phase_nxt = PH_DONE;
        end else if (op_valid) begin
          phase_nxt  = PH_KLEN;
          remain_nxt = 32'(FLD_LEN_BYTES);
        end else begin
          error_nxt = VERDICT_BAD_OP;
          phase_nxt = PH_IGNORE;
        end
      end
      PH_KLEN, PH_KEY: begin
        role_nxt   = (phase_r == PH_KLEN) ? ROLE_KLEN : ROLE_KEY;
        remain_nxt = remain_dec;
        if (phase_r == PH_KLEN) begin
          key_len_nxt = shift_klen;
        end
        if (remain_dec == 32'd0) begin
          if (phase_r == PH_KLEN && shift_klen != 32'd0) begin
            phase_nxt  = PH_KEY;
            remain_nxt = shift_klen;
          end else if (opcode_r == OP_EXPIRE) begin
            phase_nxt  = PH_EXP;
            remain_nxt = 32'(FLD_EXP_BYTES);
          end else if (opcode_r == OP_SET || opcode_r == OP_SETEXP) begin
            phase_nxt  = PH_VLEN;
            remain_nxt = 32'(FLD_LEN_BYTES);
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_VLEN, PH_VAL: begin
        role_nxt   = (phase_r == PH_VLEN) ? ROLE_VLEN : ROLE_VAL;
        remain_nxt = remain_dec;
        if (phase_r == PH_VLEN) begin
          val_len_nxt = shift_vlen;
        end
        if (remain_dec == 32'd0) begin
          if (phase_r == PH_VLEN && shift_vlen != 32'd0) begin
            phase_nxt  = PH_VAL;
            remain_nxt = shift_vlen;
          end else if (opcode_r == OP_SETEXP) begin
            phase_nxt  = PH_EXP;
            remain_nxt = 32'(FLD_EXP_BYTES);
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_EXP: begin
        role_nxt   = ROLE_EXP;
        expiry_nxt = {expiry_r[55:0], in_tdata};
        remain_nxt = remain_dec;
        if (remain_dec == 32'd0) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        role_nxt = ROLE_IGNORED;
        if (opcode_r == OP_NOOP && error_r == VERDICT_OK) begin
          error_nxt = VERDICT_NOOP_XTRA;
        end
      end
      default: begin
        role_nxt = ROLE_IGNORED;
      end
    endcase

    // expiry only shown once fully read
    res_exp_nxt = 64'd0;
    if (phase_nxt == PH_DONE && (opcode_nxt == OP_SETEXP || opcode_nxt == OP_EXPIRE)) begin
      res_exp_nxt = expiry_nxt;
    end
    verdict_nxt = VERDICT_OK;
    if (in_tlast) begin
      verdict_nxt = (phase_nxt >= PH_DONE) ? error_nxt : VERDICT_TRUNCATED;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_OP;
      remain_r  <= 32'd0;
      opcode_r  <= 8'd0;
      key_len_r <= 32'd0;
      val_len_r <= 32'd0;
      expiry_r  <= 64'd0;
      error_r   <= VERDICT_OK;
    end else if (accept) begin
      if (in_tlast) begin
        phase_r   <= PH_OP;
        remain_r  <= 32'd0;
        opcode_r  <= 8'd0;
        key_len_r <= 32'd0;
        val_len_r <= 32'd0;
        expiry_r  <= 64'd0;
        error_r   <= VERDICT_OK;
      end else begin
        phase_r   <= phase_nxt;
        remain_r  <= remain_nxt;
        opcode_r  <= opcode_nxt;
        key_len_r <= key_len_nxt;
        val_len_r <= val_len_nxt;
        expiry_r  <= expiry_nxt;
        error_r   <= error_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      role_r     <= role_nxt;
      byte_r     <= in_tdata;
      end_r      <= in_tlast;
      verdict_r  <= verdict_nxt;
      res_op_r   <= opcode_nxt;
      res_klen_r <= key_len_nxt;
      res_vlen_r <= val_len_nxt;
      res_exp_r  <= res_exp_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = role_r;
  assign out_tlast  = end_r;
  assign out_tdata  = {6'd0, res_exp_r, res_vlen_r, res_klen_r, res_op_r, verdict_r, byte_r};

endmodule

@@ test/kcmd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcmd_checker
// Watches both streams of the key/value command parser. Every accepted request
// byte runs through a local copy of the parse state to predict its result, and
// every accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module kcmd_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [7:0]                        in_tdata,
  input  logic                              in_tlast,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [kcmd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic [2:0]                        out_tuser,
  input  logic                              out_tlast,
  output int unsigned                       fail_count,
  output int unsigned                       pending,
  output int unsigned                       checked
);
  import kcmd_pkg::*;

  typedef struct {
    logic [2:0]  role;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  verdict;
    logic [7:0]  opcode;
    logic [31:0] key_len;
    logic [31:0] val_len;
    logic [63:0] expiry;
  } parse_result_t;

  logic [2:0]    stage;
  logic [31:0]   remaining;
  logic [7:0]    opc;
  logic [31:0]   key_len;
  logic [31:0]   val_len;
  logic [63:0]   expiry;
  logic [1:0]    fault;
  parse_result_t parse_results_q[$];

  function automatic void clear_parse();
    stage     = PH_OP;
    remaining = '0;
    opc       = '0;
    key_len   = '0;
    val_len   = '0;
    expiry    = '0;
    fault     = VERDICT_OK;
  endfunction

  function automatic void key_done();
    if (opc == OP_EXPIRE) begin
      stage     = PH_EXP;
      remaining = 32'(FLD_EXP_BYTES);
    end else if (opc == OP_SET || opc == OP_SETEXP) begin
      stage     = PH_VLEN;
      remaining = 32'(FLD_LEN_BYTES);
    end else begin
      stage = PH_DONE;
    end
  endfunction

  function automatic void value_done();
    if (opc == OP_SETEXP) begin
      stage     = PH_EXP;
      remaining = 32'(FLD_EXP_BYTES);
    end else begin
      stage = PH_DONE;
    end
  endfunction

  function automatic parse_result_t parse_byte(input logic [7:0] b, input logic last);
    parse_result_t r;
    r.role    = ROLE_IGNORED;
    r.data    = b;
    r.last    = last;
    r.verdict = VERDICT_OK;
    r.expiry  = '0;
    case (stage)
      PH_OP: begin
        r.role = ROLE_OP;
        opc    = b;
        if (b == OP_NOOP) begin
          stage = PH_DONE;
        end else if (b inside {OP_SET, OP_DEL, OP_SETEXP, OP_EXPIRE}) begin
          stage     = PH_KLEN;
          remaining = 32'(FLD_LEN_BYTES);
        end else begin
          fault = VERDICT_BAD_OP;
          stage = PH_IGNORE;
        end
      end
      PH_KLEN: begin
        r.role    = ROLE_KLEN;
        key_len   = {key_len[23:0], b};
        remaining = remaining - 1;
        if (remaining == 0) begin
          if (key_len == 0) begin
            key_done();
          end else begin
            stage     = PH_KEY;
            remaining = key_len;
          end
        end
      end
      PH_KEY: begin
        r.role    = ROLE_KEY;
        remaining = remaining - 1;
        if (remaining == 0) key_done();
      end
      PH_VLEN: begin
        r.role    = ROLE_VLEN;
        val_len   = {val_len[23:0], b};
        remaining = remaining - 1;
        if (remaining == 0) begin
          if (val_len == 0) begin
            value_done();
          end else begin
            stage     = PH_VAL;
            remaining = val_len;
          end
        end
      end
      PH_VAL: begin
        r.role    = ROLE_VAL;
        remaining = remaining - 1;
        if (remaining == 0) value_done();
      end
      PH_EXP: begin
        r.role    = ROLE_EXP;
        expiry    = {expiry[55:0], b};
        remaining = remaining - 1;
        if (remaining == 0) stage = PH_DONE;
      end
      PH_DONE: begin
        // anything after a noop opcode spoils the record
        if (opc == OP_NOOP && fault == VERDICT_OK) fault = VERDICT_NOOP_XTRA;
      end
      default: begin
      end
    endcase
    if (stage == PH_DONE && (opc == OP_SETEXP || opc == OP_EXPIRE)) r.expiry = expiry;
    if (last) r.verdict = (stage >= PH_DONE) ? fault : VERDICT_TRUNCATED;
    r.opcode  = opc;
    r.key_len = key_len;
    r.val_len = val_len;
    if (last) clear_parse();
    return r;
  endfunction

  task automatic report(input string msg);
    if (fail_count < 40) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h expected %0h", checked, name, got, want));
  endtask

  always @(posedge clk) begin
    parse_result_t want;
    if (!rst_n) begin
      clear_parse();
      parse_results_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        parse_results_q.insert(parse_results_q.size(), parse_byte(in_tdata, in_tlast));
      if (out_tvalid && out_tready) begin
        if (parse_results_q.size() == 0) begin
          report($sformatf("result with no request pending, role %0d byte %02h",
                           out_tuser, out_tdata[7:0]));
        end else begin
          want = parse_results_q.pop_front();
          check_field("byte_role", 64'(out_tuser), 64'(want.role));
          check_field("byte_out", 64'(out_tdata[7:0]), 64'(want.data));
          check_field("record_end", 64'(out_tlast), 64'(want.last));
          check_field("verdict", 64'(out_tdata[9:8]), 64'(want.verdict));
          check_field("op_code", 64'(out_tdata[17:10]), 64'(want.opcode));
          check_field("key_length", 64'(out_tdata[49:18]), 64'(want.key_len));
          check_field("value_length", 64'(out_tdata[81:50]), 64'(want.val_len));
          check_field("expiry_ms", out_tdata[145:82], want.expiry);
          check_field("zero fill", 64'(out_tdata[151:146]), 64'd0);
          checked++;
        end
      end
    end
    pending = parse_results_q.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives command records into key_value_command_parser: a few hand-picked
// records covering every opcode, bad and noop cases, zero and huge lengths and
// truncation, then random records, mostly well formed, with random gaps on
// the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import kcmd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TARGET_BYTES   = 1000;
  localparam int unsigned BODY_CAP       = 48;

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [7:0]              in_tdata   = '0;
  logic                    in_tlast   = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic [2:0]              out_tuser;
  logic                    out_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent  = 0;
  int unsigned records     = 0;
  logic        steady      = 1'b0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  key_value_command_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  kcmd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // result side stalls
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("key_value_command_parser test failed");
      $finish;
    end
  end

  // called and returns just after a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // cut: 0 keeps the whole record, negative cuts at random, positive keeps that many
  task automatic send_record(input logic [7:0] op, input logic [31:0] klen,
                             input logic [31:0] vlen, input logic [63:0] exp_val,
                             input int cut, input int extra);
    logic [7:0] rec_bytes[$];
    int         keep;
    rec_bytes.insert(rec_bytes.size(), op);
    if (op inside {OP_SET, OP_DEL, OP_SETEXP, OP_EXPIRE}) begin
      for (int i = 3; i >= 0; i--) rec_bytes.insert(rec_bytes.size(), klen[8*i +: 8]);
      for (int i = 0; i < klen && i < BODY_CAP; i++)
        rec_bytes.insert(rec_bytes.size(), 8'($urandom_range(255)));
      if (op == OP_SET || op == OP_SETEXP) begin
        for (int i = 3; i >= 0; i--) rec_bytes.insert(rec_bytes.size(), vlen[8*i +: 8]);
        for (int i = 0; i < vlen && i < BODY_CAP; i++)
          rec_bytes.insert(rec_bytes.size(), 8'($urandom_range(255)));
      end
      if (op == OP_SETEXP || op == OP_EXPIRE)
        for (int i = 7; i >= 0; i--) rec_bytes.insert(rec_bytes.size(), exp_val[8*i +: 8]);
    end
    keep = rec_bytes.size();
    if (cut < 0 && keep > 1) keep = $urandom_range(keep - 1, 1);
    else if (cut > 0 && cut < keep) keep = cut;
    while (rec_bytes.size() > keep) void'(rec_bytes.pop_back());
    repeat (extra) rec_bytes.insert(rec_bytes.size(), 8'($urandom_range(255)));
    foreach (rec_bytes[i]) send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
    records++;
  endtask

  function automatic logic [31:0] pick_length();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(6);
    if (p < 95) return $urandom_range(40, 7);
    return $urandom;
  endfunction

  function automatic logic [63:0] pick_expiry();
    int unsigned p;
    p = $urandom_range(9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(3))
      0:       return OP_SET;
      1:       return OP_DEL;
      2:       return OP_SETEXP;
      default: return OP_EXPIRE;
    endcase
  endfunction

  initial begin
    int unsigned p;
    logic [7:0]  bad;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // hand-picked records
    send_record(OP_NOOP, 0, 0, 0, 0, 0);
    send_record(OP_NOOP, 0, 0, 0, 0, 2);
    send_record(8'h00, 0, 0, 0, 0, 0);
    send_record(8'hFF, 0, 0, 0, 0, 3);
    send_record(OP_DEL, 0, 0, 0, 0, 0);
    send_record(OP_SET, 1, 1, 0, 0, 0);
    send_record(OP_SETEXP, 0, 0, '1, 0, 0);
    send_record(OP_EXPIRE, 2, 0, 64'h0123_4567_89AB_CDEF, 0, 2);
    send_record(OP_SET, 32'hFFFF_FFFF, 0, 0, 7, 0);
    send_record(OP_SETEXP, 0, 0, 64'hFEDC_BA98_7654_3210, 14, 0);
    send_record(OP_SET, 0, 32'hFFFF_FFFF, 0, 12, 0);

    // random records; one stretch runs with no gaps or stalls at all
    while (bytes_sent < TARGET_BYTES) begin
      steady = (bytes_sent >= 350 && bytes_sent < 550);
      p = $urandom_range(99);
      if (p < 70) begin
        send_record(pick_opcode(), pick_length(), pick_length(), pick_expiry(), 0,
                    (p < 12) ? $urandom_range(3, 1) : 0);
      end else if (p < 80) begin
        send_record(pick_opcode(), pick_length(), pick_length(), pick_expiry(), -1, 0);
      end else if (p < 88) begin
        do bad = 8'($urandom_range(255));
        while (bad inside {OP_SET, OP_DEL, OP_SETEXP, OP_EXPIRE, OP_NOOP});
        send_record(bad, 0, 0, 0, 0, $urandom_range(4));
      end else begin
        send_record(OP_NOOP, 0, 0, 0, 0, $urandom_range(3));
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("sent %0d command records as %0d bytes, %0d results compared, %0d mismatches",
             records, bytes_sent, checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("key_value_command_parser test passed");
    end else begin
      $display("key_value_command_parser test failed");
    end
    $finish;
  end

endmodule

@@ key_value_command_parser.f @@
design/kcmd_pkg.sv
design/key_value_command_parser.sv
test/kcmd_checker.sv
test/tb_top.sv
